// File: src/rdq_pkg.sv
// Shared types and constants for the reversible deque.
// No dependencies; every other file in src refers to this package by scoped names.
package rdq_pkg;

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned COUNT_W = 7;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_REVERSE = 2'd2,
      OP_REMOVE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef logic [DATA_W-1:0] data_type;

   typedef struct packed {
      op_type   op;
      data_type value;
   } req_type;

   typedef struct packed {
      data_type             removed_value;
      status_type           status;
      logic [COUNT_W-1:0]   element_count;
      logic                 is_reversed;
      logic                 error_latched;
   } rsp_type;

endpackage

// File: src/rdq_store.sv
// Element storage for the deque: one write port, one read port, registered read data.
// Depends on rdq_pkg for the element type.
module rdq_store #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  rdq_pkg::data_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output rdq_pkg::data_type rd_data
);

   rdq_pkg::data_type mem [DEPTH];
   rdq_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/reversible_deque_with_error.sv
// Ring-buffer deque with lazy reverse and sticky error.
// The result of a transfer is registered and valid in the cycle after it is accepted.
// Throughput: one operation per cycle; the result register and the registered
// storage read advance together, so a new request is taken whenever the
// result register is empty or being drained in the same cycle.
// Reset: synchronous, clears pointer, count, direction, error and result valid.
module reversible_deque_with_error #(
   parameter int unsigned DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rdq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rdq_pkg::rsp_type rsp_payload
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic          rev_ff, rev_in;
   logic          err_ff, err_in;

   logic                 rsp_valid_ff;
   rdq_pkg::status_type  stat_ff, stat_in;
   logic                 take_ff, take_in;
   logic [CW-1:0]        cnt_ff;
   logic                 rrev_ff, rerr_ff;

   logic              accept;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   rdq_pkg::data_type rd_data;

   logic          is_full, is_empty;
   logic [AW-1:0] head_dec, head_inc, tail_idx, back_idx;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
      logic [AW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign is_full  = (occ_ff == CW'(DEPTH));
   assign is_empty = (occ_ff == '0);
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign tail_idx = wrap_add(head_ff, AW'(occ_ff));
   assign back_idx = wrap_add(head_ff, AW'(occ_ff - 1'b1));

   always_comb begin
      head_in = head_ff;
      occ_in  = occ_ff;
      rev_in  = rev_ff;
      err_in  = err_ff;
      stat_in = rdq_pkg::ST_OK;
      take_in = 1'b0;
      wr_en   = 1'b0;
      wr_addr = tail_idx;
      rd_en   = 1'b0;
      rd_addr = head_ff;
      unique case (req_payload.op)
         rdq_pkg::OP_CLEAR: begin
            head_in = '0;
            occ_in  = '0;
            rev_in  = 1'b0;
            err_in  = 1'b0;
         end
         rdq_pkg::OP_APPEND: begin
            if (is_full) begin
               stat_in = rdq_pkg::ST_FULL;
            end else begin
               wr_en  = accept;
               occ_in = occ_ff + 1'b1;
               if (rev_ff) begin
                  head_in = head_dec;
                  wr_addr = head_dec;
               end
            end
         end
         rdq_pkg::OP_REVERSE: begin
            if (err_ff) begin
               stat_in = rdq_pkg::ST_IGNORED;
            end else begin
               rev_in = !rev_ff;
            end
         end
         rdq_pkg::OP_REMOVE: begin
            priority if (err_ff) begin
               stat_in = rdq_pkg::ST_IGNORED;
            end else if (is_empty) begin
               err_in  = 1'b1;
               stat_in = rdq_pkg::ST_EMPTY;
            end else begin
               take_in = 1'b1;
               rd_en   = accept;
               occ_in  = occ_ff - 1'b1;
               if (rev_ff) begin
                  rd_addr = back_idx;
               end else begin
                  head_in = head_inc;
               end
            end
         end
         default: begin
            stat_in = rdq_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         occ_ff       <= '0;
         rev_ff       <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            head_ff <= head_in;
            occ_ff  <= occ_in;
            rev_ff  <= rev_in;
            err_ff  <= err_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stat_ff <= stat_in;
         take_ff <= take_in;
         cnt_ff  <= occ_in;
         rrev_ff <= rev_in;
         rerr_ff <= err_in;
      end
   end

   rdq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_payload.removed_value = take_ff ? rd_data : '0;
   assign rsp_payload.status        = stat_ff;
   assign rsp_payload.element_count = rdq_pkg::COUNT_W'(cnt_ff);
   assign rsp_payload.is_reversed   = rrev_ff;
   assign rsp_payload.error_latched = rerr_ff;

endmodule
